@@ sv/ibcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ibcs_pkg
// shared types, constants and helpers for the imu bias calibrate and smooth block
// ----------------------------------------------------------------------------
`default_nettype none
package ibcs_pkg;
  localparam int AXES = 6;
  localparam int WINDOW_DEPTH = 4;
  localparam int SLOT_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int COUNT_BITS = 16;
  localparam int AXIS_BITS = 3;
  localparam int SUM_BITS = 48;
  localparam int WSUM_BITS = 34;
  localparam int QUO_BITS = 48;
  localparam int DIV_STEP_BITS = 6;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MS = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRAVITY = 1'd1;

  localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
  localparam logic [23:0] GRAVITY_RESET = 24'd642690;
  localparam logic [2:0] ACCEL_Z_AXIS = 3'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] gyro_x;
    logic [31:0] gyro_y;
    logic [31:0] gyro_z;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] smooth_accel_x;
    logic [31:0] smooth_accel_y;
    logic [31:0] smooth_accel_z;
    logic [31:0] smooth_gyro_x;
    logic [31:0] smooth_gyro_y;
    logic [31:0] smooth_gyro_z;
    logic        calib_active;
    logic        calib_done;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic                 load;       // capture input sample
    logic                 open_win;   // clear calib sums and count
    logic                 accum;      // add sample into calib sums
    logic                 clr_smooth; // clear smoothing windows
    logic                 bias_start; // start bias division for axis
    logic                 bias_write; // write bias for axis
    logic                 smooth_upd; // correct sample and update window, axis
    logic                 avg_start;  // start average division for axis
    logic                 avg_write;  // write average for axis
    logic                 advance;    // advance slot and fill
    logic [AXIS_BITS-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic                 div_busy;
    logic                 count_full;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/ibcs_stream_if.sv @@
// ----------------------------------------------------------------------------
// ibcs_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none
interface ibcs_stream_if #(type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/ibcs_divider.sv @@
// ----------------------------------------------------------------------------
// ibcs_divider
// restoring divider, signed numerator, round half away from zero
// ----------------------------------------------------------------------------
`default_nettype none
module ibcs_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [ibcs_pkg::SUM_BITS-1:0] num,
  input  wire logic [ibcs_pkg::COUNT_BITS-1:0]    den,
  output logic                                    busy,
  output logic signed [ibcs_pkg::SUM_BITS+1:0]    quo
);
  localparam int QB = ibcs_pkg::QUO_BITS;
  localparam int DB = ibcs_pkg::COUNT_BITS;
  localparam int CB = $clog2(QB + 1);

  logic [QB-1:0] q;
  logic [DB:0]   rem;
  logic [DB-1:0] d;
  logic          neg;
  logic [CB-1:0] cnt;
  logic [DB:0]   trial;
  logic [QB-1:0] mag;

  assign mag = num[QB-1] ? (QB)'(-num) : num[QB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // numerator pre-added with den/2; one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= mag + QB'(den >> 1);
      rem <= '0;
      d   <= den;
      neg <= num[QB-1];
      cnt <= CB'(QB);
    end else if (busy && cnt != '0) begin
      rem <= trial >= {1'b0, d} ? trial - {1'b0, d} : trial;
      q   <= {q[QB-2:0], trial >= {1'b0, d}};
      cnt <= cnt - 1'b1;
    end
  end

  // mag + den/2 fits since the sum stays below 2^47 + 2^15
  assign trial = {rem[DB-1:0], q[QB-1]};
  assign quo = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
endmodule
`default_nettype wire

@@ sv/ibcs_datapath.sv @@
// ----------------------------------------------------------------------------
// ibcs_datapath
// calibration sums, biases, smoothing windows and result register
// ----------------------------------------------------------------------------
`default_nettype none
module ibcs_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ibcs_pkg::in_beat_t    in_beat,
  input  wire ibcs_pkg::dp_cmd_t     dcmd,
  input  wire logic [23:0]           gravity,
  output ibcs_pkg::dp_status_t       status,
  output logic [31:0]                avg [ibcs_pkg::AXES]
);
  localparam int AX = ibcs_pkg::AXES;
  localparam int WD = ibcs_pkg::WINDOW_DEPTH;
  localparam int SB = ibcs_pkg::SUM_BITS;
  localparam int WB = ibcs_pkg::WSUM_BITS;
  localparam int CB = ibcs_pkg::COUNT_BITS;
  localparam int FB = ibcs_pkg::FILL_BITS;
  localparam int PB = ibcs_pkg::SLOT_BITS;
  localparam int MB = $clog2(AX * WD);

  logic signed [31:0] raw [AX];
  logic signed [SB-1:0] calib_sums [AX];
  logic signed [31:0] axis_bias [AX];
  logic signed [WB-1:0] window_sums [AX];
  logic signed [31:0] window_store [AX * WD];
  logic [CB-1:0] sample_count;
  logic [PB-1:0] write_slot;
  logic [FB-1:0] fill_level;
  logic signed [31:0] old_val;
  logic signed [31:0] corr;
  logic signed [SB+1:0] quo;
  logic div_start;
  logic div_busy;
  logic signed [SB-1:0] div_num;
  logic [CB-1:0] div_den;
  logic [MB-1:0] addr;
  logic full;

  assign full = fill_level == FB'(WD);
  assign addr = MB'(dcmd.axis * WD) + MB'(write_slot);
  assign status = '{div_busy: div_busy, count_full: sample_count == {CB{1'b1}}};
  assign corr = ibcs_pkg::sat32(50'(raw[dcmd.axis]) + 50'(axis_bias[dcmd.axis]));
  assign div_start = dcmd.bias_start | dcmd.avg_start;
  assign div_num = dcmd.bias_start ? calib_sums[dcmd.axis] : SB'(window_sums[dcmd.axis]);
  assign div_den = dcmd.bias_start ? sample_count : CB'(fill_level);

  ibcs_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(quo)
  );

  // old entry is registered during the controller read step and used by the update step
  always_ff @(posedge clk) begin
    old_val <= window_store[addr];
    if (dcmd.smooth_upd) begin
      window_store[addr] <= corr;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      raw[0] <= in_beat.accel_x;
      raw[1] <= in_beat.accel_y;
      raw[2] <= in_beat.accel_z;
      raw[3] <= in_beat.gyro_x;
      raw[4] <= in_beat.gyro_y;
      raw[5] <= in_beat.gyro_z;
    end
    if (dcmd.avg_write) begin
      avg[dcmd.axis] <= quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      write_slot   <= '0;
      fill_level   <= '0;
      for (int a = 0; a < AX; a++) begin
        calib_sums[a]  <= '0;
        axis_bias[a]   <= '0;
        window_sums[a] <= '0;
      end
    end else begin
      if (dcmd.open_win) begin
        sample_count <= '0;
        for (int a = 0; a < AX; a++) calib_sums[a] <= '0;
      end else if (dcmd.accum) begin
        sample_count <= sample_count + 1'b1;
        for (int a = 0; a < AX; a++) begin
          if (51'(calib_sums[a]) + 51'(raw[a]) > 51'sh7fffffffffff) begin
            calib_sums[a] <= {1'b0, {(SB-1){1'b1}}};
          end else if (51'(calib_sums[a]) + 51'(raw[a]) < -51'sh800000000000) begin
            calib_sums[a] <= {1'b1, {(SB-1){1'b0}}};
          end else begin
            calib_sums[a] <= calib_sums[a] + SB'(raw[a]);
          end
        end
      end
      if (dcmd.bias_write) begin
        axis_bias[dcmd.axis] <= ibcs_pkg::sat32(
          ((dcmd.axis == ibcs_pkg::ACCEL_Z_AXIS) ? $signed({26'd0, gravity}) : 50'sd0)
          - quo);
      end
      if (dcmd.clr_smooth) begin
        write_slot <= '0;
        fill_level <= '0;
        for (int a = 0; a < AX; a++) window_sums[a] <= '0;
      end else begin
        if (dcmd.smooth_upd) begin
          window_sums[dcmd.axis] <= window_sums[dcmd.axis] + WB'(corr)
            - (full ? WB'(old_val) : WB'(0));
        end
        if (dcmd.advance) begin
          if (!full) fill_level <= fill_level + 1'b1;
          write_slot <= (WD == 1 || 32'(write_slot) == WD - 1) ? '0 : write_slot + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/ibcs_controller.sv @@
// ----------------------------------------------------------------------------
// ibcs_controller
// sequencer for commands, calibration window and per-axis division steps
// ----------------------------------------------------------------------------
`default_nettype none
module ibcs_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            in_cmd,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire logic [15:0]           window_ms,
  input  wire ibcs_pkg::dp_status_t  status,
  output ibcs_pkg::dp_cmd_t          dcmd,
  output logic                       calib_active,
  output logic                       calib_done
);
  localparam logic [2:0] LAST_AXIS = 3'(ibcs_pkg::AXES - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CAL   = 9'b000000010,
    S_BSTRT = 9'b000000100,
    S_BWAIT = 9'b000001000,
    S_RD    = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_ASTRT = 9'b001000000,
    S_AWAIT = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic request_pending, calibrating, closing;
  logic [15:0] elapsed_ms;
  logic [2:0] axis;
  logic accept;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign accept = in_valid && in_ready;
  assign calib_active = calibrating;

  always_comb begin
    state_next = state;
    dcmd = '0;
    dcmd.axis = axis;
    case (state)
      S_IDLE: begin
        if (accept && in_cmd == ibcs_pkg::CMD_SAMPLE) begin
          dcmd.load = 1'b1;
          dcmd.open_win = request_pending && !calibrating;
          state_next = S_CAL;
        end
      end
      S_CAL: begin
        dcmd.accum = calibrating && !status.count_full;
        state_next = (calibrating && elapsed_ms >= window_ms) ? S_BSTRT : S_RD;
      end
      S_BSTRT: begin
        dcmd.bias_start = 1'b1;
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        if (!status.div_busy) begin
          dcmd.bias_write = 1'b1;
          dcmd.clr_smooth = axis == LAST_AXIS;
          state_next = axis == LAST_AXIS ? S_RD : S_BSTRT;
        end
      end
      S_RD: state_next = S_UPD;
      S_UPD: begin
        dcmd.smooth_upd = 1'b1;
        dcmd.advance = axis == LAST_AXIS;
        state_next = axis == LAST_AXIS ? S_ASTRT : S_RD;
      end
      S_ASTRT: begin
        dcmd.avg_start = 1'b1;
        state_next = S_AWAIT;
      end
      S_AWAIT: begin
        if (!status.div_busy) begin
          dcmd.avg_write = 1'b1;
          state_next = axis == LAST_AXIS ? S_OUT : S_ASTRT;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      request_pending <= 1'b1;
      calibrating     <= 1'b0;
      elapsed_ms      <= '0;
      axis            <= '0;
      calib_done      <= 1'b0;
      closing         <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_cmd == ibcs_pkg::CMD_REQUEST) request_pending <= 1'b1;
      if (accept && in_cmd == ibcs_pkg::CMD_TICK && elapsed_ms != 16'hffff) begin
        elapsed_ms <= elapsed_ms + 1'b1;
      end
      if (dcmd.open_win) begin
        request_pending <= 1'b0;
        calibrating     <= 1'b1;
        elapsed_ms      <= '0;
      end
      if (dcmd.load) begin
        calib_done <= 1'b0;
        axis       <= '0;
      end
      if (state == S_CAL) begin
        closing <= calibrating && elapsed_ms >= window_ms;
      end
      if (dcmd.bias_write) begin
        axis <= axis == LAST_AXIS ? '0 : axis + 1'b1;
        if (axis == LAST_AXIS) begin
          calibrating <= 1'b0;
          calib_done  <= closing;
        end
      end
      if (dcmd.smooth_upd || dcmd.avg_write) begin
        axis <= axis == LAST_AXIS ? '0 : axis + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/imu_bias_calibrate_and_smooth.sv @@
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_smooth
// bias calibration and 4-deep moving average for six-axis imu samples
// ----------------------------------------------------------------------------
// in_ch carries a command and six raw Q15.16 axes; a sample beat (cmd 0)
// gives exactly one out_ch beat, request and tick beats give none.
// cfg_we / cfg_index / cfg_data write calib_window_ms (0) and
// gravity_target (1); the user must write them only while the block is
// idle, which the block does not enforce. one beat is worked at a time;
// in_ch.ready is high only when idle. a sample beat uses the shared
// 48-step restoring divider once per axis for the moving average, and
// once more per axis for the bias when it closes a calibration window.
// the result is held in out_ch until taken; a stalled receiver holds the
// block and no new beat is accepted.
// reset leaves a calibration request pending, biases and windows cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_bias_calibrate_and_smooth (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  ibcs_stream_if.sink                                in_ch,
  ibcs_stream_if.source                              out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [ibcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [ibcs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  logic [15:0] window_ms;
  logic [23:0] gravity;
  ibcs_pkg::dp_cmd_t dcmd;
  ibcs_pkg::dp_status_t status;
  ibcs_pkg::in_beat_t in_beat;
  logic [31:0] avg [ibcs_pkg::AXES];
  logic active, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= ibcs_pkg::WINDOW_MS_RESET;
      gravity   <= ibcs_pkg::GRAVITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ibcs_pkg::REG_WINDOW_MS: window_ms <= cfg_data[15:0];
        ibcs_pkg::REG_GRAVITY: gravity <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign in_beat = in_ch.payload;

  ibcs_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_cmd(in_beat.cmd),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .window_ms(window_ms), .status(status), .dcmd(dcmd),
    .calib_active(active), .calib_done(done)
  );

  ibcs_datapath u_dp (
    .clk(clk), .rst(rst), .in_beat(in_beat), .dcmd(dcmd), .gravity(gravity),
    .status(status), .avg(avg)
  );

  assign out_ch.payload = '{smooth_accel_x: avg[0], smooth_accel_y: avg[1],
                            smooth_accel_z: avg[2], smooth_gyro_x: avg[3],
                            smooth_gyro_y: avg[4], smooth_gyro_z: avg[5],
                            calib_active: active, calib_done: done};
endmodule
`default_nettype wire
